FILE: hdl/sensorless_bldc_six_step_commutator_assert.svh
`ifndef SENSORLESS_BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH
`define SENSORLESS_BLDC_SIX_STEP_COMMUTATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define BLDC6_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bldc6 check failed");

// Next-cycle implication, also checked across reset.
`define BLDC6_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("bldc6 check failed");

`endif

FILE: hdl/bldc6_pkg.sv
package bldc6_pkg;

  localparam int DUTY_W = 8;
  localparam int IVL_W  = 10;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  // Exact x/25 for x below 2**16: (x * 83887) >> 21.
  localparam int DIV25_MUL_W = 17;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 17'd83887;
  localparam int DIV25_SHIFT = 21;

  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AIM_DUTY       = 8'd0,
    REG_START_INTERVAL = 8'd1,
    REG_RAMP_STEP      = 8'd2,
    REG_START_STEPS    = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_CMP  = 2'd1,
    FUNC_KEY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  localparam logic [2:0] LOW_A = 3'h1;
  localparam logic [2:0] LOW_B = 3'h2;
  localparam logic [2:0] LOW_C = 3'h4;

  localparam logic [2:0] FIRST_PATTERN = 3'd3;
  localparam logic [7:0] STEP_COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0]        aim_duty;
    logic [9:0]        start_interval;
    logic [3:0]        ramp_step;
    logic [7:0]        start_steps;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        phase_levels;
    logic [1:0]        sensed_phase;
    logic              bemf_en;
    logic              gate_on;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [2:0]        low_sw;
    logic [DUTY_W-1:0] start_duty;
    logic [IVL_W-1:0]  step_interval;
    logic [IVL_W-1:0]  tick_count;
    logic [7:0]        step_count;
    logic [2:0]        start_phase;
  } state_t;

  // Output item as laid out on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [4:0] pad;
    logic [2:0] bemf_pattern;
    logic [1:0] motor_mode;
    logic [1:0] sense_phase;
    logic       gate_enable;
    logic       low_c;
    logic       low_b;
    logic       low_a;
    logic [7:0] duty_c;
    logic [7:0] duty_b;
    logic [7:0] duty_a;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] drv;
    logic [2:0] low;
  } comm_t;

  // Commutation table: pattern selects the driven phase and the low side.
  function automatic comm_t comm_lookup(input logic [2:0] pat);
    comm_t c;
    c = '0;
    case (pat)
      3'd3:    c = '{1'b1, PH_A, LOW_B};
      3'd2:    c = '{1'b1, PH_A, LOW_C};
      3'd6:    c = '{1'b1, PH_B, LOW_C};
      3'd4:    c = '{1'b1, PH_B, LOW_A};
      3'd5:    c = '{1'b1, PH_C, LOW_A};
      3'd1:    c = '{1'b1, PH_C, LOW_B};
      default: c = '0;
    endcase
    return c;
  endfunction

  // Open-loop start order 3,2,6,4,5,1.
  function automatic logic [2:0] next_pattern(input logic [2:0] pat);
    logic [2:0] n;
    case (pat)
      3'd3:    n = 3'd2;
      3'd2:    n = 3'd6;
      3'd6:    n = 3'd4;
      3'd4:    n = 3'd5;
      3'd5:    n = 3'd1;
      3'd1:    n = 3'd3;
      default: n = pat;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/bldc6_step.sv
module bldc6_step
  import bldc6_pkg::*;
(
  input  state_t     st,
  input  cfg_t       cfg,
  input  logic [1:0] func,
  input  logic       cmp_level,
  output state_t     st_next
);

  localparam int PROD_W = IVL_W + DIV25_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [IVL_W-1:0]  ivl_div25;
  logic [IVL_W:0]    tick_inc;
  logic [DUTY_W:0]   ramp_sum;
  logic [DUTY_W-1:0] aim_ext;
  logic [2:0]        level_bit;
  logic [2:0]        levels_new;
  logic              do_comm;
  logic [2:0]        comm_pat;
  logic [DUTY_W-1:0] comm_duty;
  comm_t             comm;

  assign prod      = PROD_W'(st.step_interval) * PROD_W'(DIV25_MUL);
  assign ivl_div25 = prod[DIV25_SHIFT +: IVL_W];
  assign tick_inc  = {1'b0, st.tick_count} + (IVL_W+1)'(1);
  assign aim_ext   = DUTY_W'(cfg.aim_duty);
  assign ramp_sum  = {1'b0, st.start_duty} + (DUTY_W+1)'(cfg.ramp_step);

  always_comb begin
    case (st.sensed_phase)
      PH_A:    level_bit = LOW_B;
      PH_B:    level_bit = LOW_A;
      PH_C:    level_bit = LOW_C;
      default: level_bit = 3'b000;
    endcase
    if (cmp_level) begin
      levels_new = st.phase_levels | level_bit;
    end else begin
      levels_new = st.phase_levels & ~level_bit;
    end
  end

  always_comb begin
    st_next   = st;
    do_comm   = 1'b0;
    comm_pat  = st.start_phase;
    comm_duty = st.start_duty;
    case (func)
      FUNC_TICK: begin
        if (st.mode == MODE_START) begin
          if (tick_inc >= {1'b0, st.step_interval}) begin
            st_next.tick_count    = '0;
            st_next.step_interval = st.step_interval - ivl_div25;
            do_comm = 1'b1;
            // A pattern outside the start order maps to itself.
            st_next.start_phase = next_pattern(st.start_phase);
            if (st.step_count >= cfg.start_steps) begin
              st_next.bemf_en = 1'b1;
              st_next.mode    = MODE_RUN;
            end else if (st.start_duty < aim_ext) begin
              st_next.start_duty = ramp_sum[DUTY_W] ? DUTY_MAX : ramp_sum[DUTY_W-1:0];
            end else begin
              st_next.start_duty = aim_ext;
            end
            if (st.step_count != STEP_COUNT_MAX) begin
              st_next.step_count = st.step_count + 8'd1;
            end
          end else begin
            st_next.tick_count = tick_inc[IVL_W-1:0];
          end
        end
      end
      FUNC_CMP: begin
        st_next.phase_levels = levels_new;
        do_comm   = st.bemf_en;
        comm_pat  = levels_new;
        comm_duty = aim_ext;
        st_next.sensed_phase = (st.sensed_phase >= PH_C) ? PH_A : st.sensed_phase + 2'd1;
      end
      FUNC_KEY: begin
        if (st.mode == MODE_IDLE) begin
          st_next.gate_on       = 1'b1;
          st_next.start_duty    = '0;
          st_next.tick_count    = '0;
          st_next.step_count    = '0;
          st_next.start_phase   = FIRST_PATTERN;
          st_next.step_interval = IVL_W'(cfg.start_interval);
          st_next.mode          = MODE_START;
        end else if (st.mode == MODE_RUN) begin
          st_next.bemf_en = 1'b0;
          st_next.gate_on = 1'b0;
          st_next.low_sw  = '0;
          st_next.mode    = MODE_IDLE;
        end
      end
      default: begin
        st_next = st;
      end
    endcase

    comm = comm_lookup(comm_pat);
    if (do_comm && comm.hit) begin
      st_next.duty_a = (comm.drv == PH_A) ? comm_duty : '0;
      st_next.duty_b = (comm.drv == PH_B) ? comm_duty : '0;
      st_next.duty_c = (comm.drv == PH_C) ? comm_duty : '0;
      st_next.low_sw = comm.low;
    end
  end

endmodule

FILE: hdl/sensorless_bldc_six_step_commutator.sv
// Channel   Direction  Payload
// s_axis    in         tuser[1:0] func; tdata[0] cmp_level
// m_axis    out        tdata[39:0] one result item per input item
// cfg       in         cfg_addr register index, cfg_data value, always ready
//
// The next-state logic sits between the state registers and a two-entry
// output stage, so an item can be accepted on every clock edge while the
// skid entry is empty. s_axis_tready drops only while both output entries
// are full, that is while the sink stalls with a second result waiting.
// Reset is synchronous and puts the motor in idle with all gates off and
// the configuration registers at their defaults; no clearing pass is needed.
module sensorless_bldc_six_step_commutator
  import bldc6_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input item, fields from bit 0 up: cmp_level, zero padding.
  input  logic [7:0]            s_axis_tdata,
  // Input kind, fields from bit 0 up: func.
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Result item, fields from bit 0 up: duty_a, duty_b, duty_c, low_a, low_b,
  // low_c, gate_enable, sense_phase, motor_mode, bemf_pattern, zero padding.
  output logic [39:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Motor state and the registered configuration.
  state_t    st;
  state_t    st_next;
  state_t    st_init;
  cfg_t      cfg;

  // Output stage: a main entry that drives the port and a skid entry that
  // catches one more result while the sink is stalled.
  out_item_t out_main;
  out_item_t out_skid;
  out_item_t res;
  logic      main_valid;
  logic      skid_valid;
  logic      push;
  logic      pop;

  bldc6_step u_step (
    .st        (st),
    .cfg       (cfg),
    .func      (s_axis_tuser),
    .cmp_level (s_axis_tdata[0]),
    .st_next   (st_next)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = main_valid && m_axis_tready;
  assign m_axis_tvalid = main_valid;
  assign m_axis_tdata  = out_main;

  // State after reset: everything clear, idle, start order at its first pattern.
  always_comb begin
    st_init             = '0;
    st_init.mode        = MODE_IDLE;
    st_init.start_phase = FIRST_PATTERN;
  end

  // The result item reports the state after the item has been applied.
  always_comb begin
    res              = '0;
    res.duty_a       = st_next.duty_a[7:0];
    res.duty_b       = st_next.duty_b[7:0];
    res.duty_c       = st_next.duty_c[7:0];
    res.low_a        = st_next.low_sw[0];
    res.low_b        = st_next.low_sw[1];
    res.low_c        = st_next.low_sw[2];
    res.gate_enable  = st_next.gate_on;
    res.sense_phase  = st_next.sensed_phase;
    res.motor_mode   = st_next.mode;
    res.bemf_pattern = st_next.phase_levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_init;
    end else if (push) begin
      st <= st_next;
    end
  end

  // Configuration is to be written only while the block is idle; the block
  // does not enforce it and takes writes unordered against the item stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aim_duty       <= 8'd100;
      cfg.start_interval <= 10'd120;
      cfg.ramp_step      <= 4'd4;
      cfg.start_steps    <= 8'd80;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_AIM_DUTY:       cfg.aim_duty       <= cfg_data[7:0];
        REG_START_INTERVAL: cfg.start_interval <= cfg_data[9:0];
        REG_RAMP_STEP:      cfg.ramp_step      <= cfg_data[3:0];
        REG_START_STEPS:    cfg.start_steps    <= cfg_data[7:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  // A waiting skid entry always moves up first; a new item can only arrive
  // when the skid entry is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        out_main   <= out_skid;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_main   <= res;
        main_valid <= push;
      end
    end else if (push) begin
      out_skid   <= res;
      skid_valid <= 1'b1;
    end
  end

endmodule

FILE: hdl/bldc6_checker.sv
`include "sensorless_bldc_six_step_commutator_assert.svh"

module bldc6_checker
  import bldc6_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic [39:0]           m_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready
);

  out_item_t r;

  assign r = m_axis_tdata;

  // Reset empties the output stage.
  `BLDC6_ASSERT_NXT(a_reset_empty, rst, !m_axis_tvalid)

  // A stalled result holds its payload.
  `BLDC6_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready && !rst, $stable(m_axis_tdata))

  // Never more than one low-side switch on at a time.
  `BLDC6_ASSERT_IMP(a_low_onehot, m_axis_tvalid, $onehot0({r.low_c, r.low_b, r.low_a}))

  // The gates are enabled exactly while the motor is starting or running.
  `BLDC6_ASSERT_IMP(a_gate_mode, m_axis_tvalid, r.gate_enable == (r.motor_mode != MODE_IDLE))

  // In idle every low-side switch is off.
  `BLDC6_ASSERT_IMP(a_idle_low_off, m_axis_tvalid && (r.motor_mode == MODE_IDLE), {r.low_c, r.low_b, r.low_a} == 3'b000)

endmodule

bind sensorless_bldc_six_step_commutator bldc6_checker u_bldc6_checker (.*);

FILE: tb/sv/commutator_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and register channels of the commutator, keeps its
// own copy of the motor state and checks every result against it.
module commutator_checker
  import bldc6_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [39:0]           m_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output mode_t                 mode_now
);

  localparam logic [7:0] AIM_RESET   = 8'd100;
  localparam logic [9:0] IVL_RESET   = 10'd120;
  localparam logic [3:0] RAMP_RESET  = 4'd4;
  localparam logic [7:0] STEPS_RESET = 8'd80;
  localparam logic [7:0] STEPS_SAT   = 8'd255;

  // Bit that each sensed phase owns in the back-EMF pattern.
  localparam logic [2:0] LVL_A = 3'b010;
  localparam logic [2:0] LVL_B = 3'b001;
  localparam logic [2:0] LVL_C = 3'b100;

  // Open-loop start order, first pattern in the lowest three bits.
  localparam logic [17:0] START_ORDER = {3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3};
  localparam logic [2:0]  ORDER_LAST  = 3'd5;

  logic [7:0]  aim_r;
  logic [9:0]  ivl_r;
  logic [3:0]  ramp_r;
  logic [7:0]  steps_r;

  mode_t       mode_q;
  logic [2:0]  levels_q;
  logic [1:0]  sensed_q;
  logic        bemf_q;
  logic        gate_q;
  logic [7:0]  duty_q [3];
  logic [2:0]  low_q;
  logic [7:0]  ramp_duty_q;
  logic [9:0]  ivl_q;
  logic [9:0]  ticks_q;
  logic [7:0]  nsteps_q;
  logic [2:0]  order_q;

  out_item_t   results_due [$];

  function automatic void reset_model();
    aim_r       = AIM_RESET;
    ivl_r       = IVL_RESET;
    ramp_r      = RAMP_RESET;
    steps_r     = STEPS_RESET;
    mode_q      = MODE_IDLE;
    levels_q    = '0;
    sensed_q    = PH_A;
    bemf_q      = 1'b0;
    gate_q      = 1'b0;
    duty_q[0]   = '0;
    duty_q[1]   = '0;
    duty_q[2]   = '0;
    low_q       = '0;
    ramp_duty_q = '0;
    ivl_q       = '0;
    ticks_q     = '0;
    nsteps_q    = '0;
    order_q     = '0;
    results_due.delete();
  endfunction

  // Drive one phase high with the given duty and switch one low side on.
  // Patterns outside the table leave the outputs alone.
  function automatic void drive_pattern(input logic [2:0] pat, input logic [7:0] duty);
    logic [1:0] drv;
    logic [2:0] low;
    bit         hit;
    hit = 1'b1;
    drv = PH_A;
    low = '0;
    case (pat)
      3'd3: begin drv = PH_A; low = LOW_B; end
      3'd2: begin drv = PH_A; low = LOW_C; end
      3'd6: begin drv = PH_B; low = LOW_C; end
      3'd4: begin drv = PH_B; low = LOW_A; end
      3'd5: begin drv = PH_C; low = LOW_A; end
      3'd1: begin drv = PH_C; low = LOW_B; end
      default: hit = 1'b0;
    endcase
    if (hit) begin
      duty_q[0]   = '0;
      duty_q[1]   = '0;
      duty_q[2]   = '0;
      duty_q[drv] = duty;
      low_q       = low;
    end
  endfunction

  function automatic void start_step();
    logic [8:0] sum;
    ivl_q = ivl_q - ivl_q / 10'd25;
    drive_pattern(START_ORDER[3*order_q +: 3], ramp_duty_q);
    order_q = (order_q == ORDER_LAST) ? 3'd0 : order_q + 3'd1;
    if (nsteps_q >= steps_r) begin
      bemf_q = 1'b1;
      mode_q = MODE_RUN;
    end else if (ramp_duty_q < aim_r) begin
      sum = {1'b0, ramp_duty_q} + {5'd0, ramp_r};
      ramp_duty_q = sum[8] ? DUTY_MAX : sum[7:0];
    end else begin
      ramp_duty_q = aim_r;
    end
    if (nsteps_q != STEPS_SAT)
      nsteps_q = nsteps_q + 8'd1;
  endfunction

  // Applies one input item to the state copy and returns the result it gives.
  function automatic out_item_t predict_outputs(input logic [1:0] func, input logic lvl);
    logic [2:0] sel;
    out_item_t  o;
    sel = '0;
    o   = '0;
    case (func_t'(func))
      FUNC_TICK: if (mode_q == MODE_START) begin
        if ({1'b0, ticks_q} + 11'd1 >= {1'b0, ivl_q}) begin
          ticks_q = '0;
          start_step();
        end else begin
          ticks_q = ticks_q + 10'd1;
        end
      end
      FUNC_CMP: begin
        case (sensed_q)
          PH_A:    sel = LVL_A;
          PH_B:    sel = LVL_B;
          PH_C:    sel = LVL_C;
          default: sel = '0;
        endcase
        levels_q = lvl ? (levels_q | sel) : (levels_q & ~sel);
        if (bemf_q)
          drive_pattern(levels_q, aim_r);
        sensed_q = (sensed_q >= PH_C) ? PH_A : sensed_q + 2'd1;
      end
      FUNC_KEY: begin
        if (mode_q == MODE_IDLE) begin
          gate_q      = 1'b1;
          ramp_duty_q = '0;
          ticks_q     = '0;
          nsteps_q    = '0;
          order_q     = '0;
          ivl_q       = ivl_r;
          mode_q      = MODE_START;
        end else if (mode_q == MODE_RUN) begin
          bemf_q = 1'b0;
          gate_q = 1'b0;
          low_q  = '0;
          mode_q = MODE_IDLE;
        end
      end
      default: ;
    endcase
    o.duty_a       = duty_q[PH_A];
    o.duty_b       = duty_q[PH_B];
    o.duty_c       = duty_q[PH_C];
    o.low_a        = low_q[0];
    o.low_b        = low_q[1];
    o.low_c        = low_q[2];
    o.gate_enable  = gate_q;
    o.sense_phase  = sensed_q;
    o.motor_mode   = mode_q;
    o.bemf_pattern = levels_q;
    return o;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (rst) begin
      reset_model();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_addr))
          REG_AIM_DUTY:       aim_r   = cfg_data[7:0];
          REG_START_INTERVAL: ivl_r   = cfg_data[9:0];
          REG_RAMP_STEP:      ramp_r  = cfg_data[3:0];
          REG_START_STEPS:    steps_r = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(predict_outputs(s_axis_tuser, s_axis_tdata[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        end else begin
          want = results_due.pop_front();
          check_field("duty_a", want.duty_a, got.duty_a);
          check_field("duty_b", want.duty_b, got.duty_b);
          check_field("duty_c", want.duty_c, got.duty_c);
          check_field("low_a", want.low_a, got.low_a);
          check_field("low_b", want.low_b, got.low_b);
          check_field("low_c", want.low_c, got.low_c);
          check_field("gate_enable", want.gate_enable, got.gate_enable);
          check_field("sense_phase", want.sense_phase, got.sense_phase);
          check_field("motor_mode", want.motor_mode, got.motor_mode);
          check_field("bemf_pattern", want.bemf_pattern, got.bemf_pattern);
          check_field("padding", want.pad, got.pad);
        end
      end
    end
    pending  <= results_due.size();
    mode_now <= mode_q;
  end

endmodule

FILE: tb/sv/tb_sensorless_bldc_six_step_commutator.sv
`timescale 1ns / 100ps

// Top of the commutator testbench. It makes the clock, the single reset, the
// item stream, the register writes and the sink's stall pattern; the checker
// beside the block predicts and compares every result.
module tb_sensorless_bldc_six_step_commutator;
  import bldc6_pkg::*;

  // The func field is two bits wide; the code above the key press is defined
  // as a no-op and is sent now and then as noise.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int PHASES     = 10;
  localparam int PHASE_SIZE = 120;

  logic                  clk;
  logic                  rst;
  logic [7:0]            s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [39:0]           m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  int    fail_count;
  int    pending;
  mode_t mode_now;

  // Items left in the current burst of the sender.
  int burst_left;

  sensorless_bldc_six_step_commutator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  commutator_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .mode_now      (mode_now)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The sink switches between stretches of steady readiness, coin-flip
  // readiness and heavy stalling, each of random length.
  initial begin : sink_pattern
    int style;
    int span;
    m_axis_tready = 1'b1;
    forever begin
      style = $urandom_range(0, 2);
      span  = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Sends one item and returns at the falling edge after it was taken. At the
  // end of a burst the sender drops tvalid for a random gap; a gap of zero
  // lets the next burst follow without a bubble.
  task automatic push_item(input logic [1:0] func, input logic lvl);
    int gap;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {7'd0, lvl};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Holds the sender off until every predicted result has been seen, then
  // lets the clock run on so the output stage is surely empty.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write so
  // that back-to-back writes keep the strobe high.
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_all(input int unsigned aim, input int unsigned ivl,
                           input int unsigned ramp, input int unsigned steps);
    write_reg(REG_AIM_DUTY, aim);
    write_reg(REG_START_INTERVAL, ivl);
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_START_STEPS, steps);
    cfg_valid <= 1'b0;
  endtask

  // Brings the motor back to idle: ticks finish the run-up and a key press
  // stops a running motor. Keys during the run-up would be ignored.
  task automatic stop_motor();
    while (mode_now != MODE_IDLE) begin
      if (mode_now == MODE_START)
        push_item(FUNC_TICK, 1'($urandom_range(0, 1)));
      else
        push_item(FUNC_KEY, 1'($urandom_range(0, 1)));
    end
  endtask

  // Chooses the next event so that the motor spends most of its time starting
  // and running: idle mostly sees key presses, the run-up mostly ticks and the
  // closed loop mostly comparator events, with a little of everything else.
  function automatic logic [1:0] pick_func(input mode_t m);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      MODE_IDLE:  return (r < 60) ? FUNC_KEY : (r < 80) ? FUNC_CMP :
                         (r < 95) ? FUNC_TICK : FUNC_UNUSED;
      MODE_START: return (r < 80) ? FUNC_TICK : (r < 92) ? FUNC_CMP :
                         (r < 97) ? FUNC_KEY : FUNC_UNUSED;
      default:    return (r < 80) ? FUNC_CMP : (r < 92) ? FUNC_TICK :
                         (r < 97) ? FUNC_KEY : FUNC_UNUSED;
    endcase
  endfunction

  // True for events that leave the state untouched in the given mode.
  function automatic bit no_effect(input logic [1:0] func, input mode_t m);
    return (func == FUNC_UNUSED) || (func == FUNC_TICK && m != MODE_START) ||
           (func == FUNC_KEY && m == MODE_START);
  endfunction

  initial begin : stimulus
    logic [1:0] func;
    int         counted;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    cfg_valid     = 1'b0;
    cfg_addr      = REG_AIM_DUTY;
    cfg_data      = '0;
    burst_left    = 4;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Idle with the reset settings: the no-op code, a tick that does nothing,
    // and comparator events that fill and clear the stored levels while the
    // sensed phase walks A, B, C and around.
    push_item(FUNC_UNUSED, 1'b1);
    push_item(FUNC_TICK, 1'b0);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b0);
    push_item(FUNC_CMP, 1'b0);
    wait_results_done();

    // A short, steep run-up: two ticks per step, three steps to closed loop.
    write_all(200, 2, 15, 2);
    push_item(FUNC_KEY, 1'b0);
    push_item(FUNC_KEY, 1'b1);
    push_item(FUNC_TICK, 1'b0);
    push_item(FUNC_TICK, 1'b0);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_TICK, 1'b1);
    push_item(FUNC_TICK, 1'b0);
    push_item(FUNC_TICK, 1'b0);
    push_item(FUNC_TICK, 1'b0);
    // Closed loop: patterns in and out of the table, including all-one levels,
    // then a tick and the no-op, a stop and a restart.
    push_item(FUNC_CMP, 1'b0);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b1);
    push_item(FUNC_CMP, 1'b0);
    push_item(FUNC_CMP, 1'b0);
    push_item(FUNC_TICK, 1'b1);
    push_item(FUNC_UNUSED, 1'b0);
    push_item(FUNC_KEY, 1'b1);
    push_item(FUNC_KEY, 1'b0);

    // Random phases. The first few pin the registers at chosen values: zero
    // aim and an aim of 200, a one-tick and a hundred-tick interval, ramps of 1
    // and 15, and the longest run-up; the rest draw a fresh short interval and
    // step count, and now and then a fresh aim and ramp.
    for (int p = 0; p < PHASES; p++) begin
      stop_motor();
      wait_results_done();
      case (p)
        0:       write_all(0, 1, 1, 1);
        1:       write_all(200, 5, 15, 10);
        2:       write_all(37, 30, 3, 4);
        3:       write_all(200, 1, 15, 255);
        4:       write_all(150, 100, 7, 1);
        default: begin
          if ($urandom_range(0, 1)) write_reg(REG_AIM_DUTY, $urandom_range(0, 200));
          write_reg(REG_START_INTERVAL, $urandom_range(1, 12));
          if ($urandom_range(0, 1)) write_reg(REG_RAMP_STEP, $urandom_range(1, 15));
          write_reg(REG_START_STEPS, $urandom_range(1, 20));
          cfg_valid <= 1'b0;
          @(negedge clk);
        end
      endcase
      counted = 0;
      while (counted < PHASE_SIZE) begin
        func = pick_func(mode_now);
        if (!no_effect(func, mode_now))
          counted++;
        push_item(func, 1'($urandom_range(0, 1)));
      end
    end

    // Let every outstanding result drain, then give the verdict.
    wait_results_done();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sensorless_bldc_six_step_commutator test passed");
    end else begin
      $display("sensorless_bldc_six_step_commutator test failed");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #8000000;
    $display("sensorless_bldc_six_step_commutator test failed");
    $finish;
  end

endmodule
